### design/aes128_block_encrypt_core_macros.svh
// Assertion macros shared by the AES-128 encryption core.
`ifndef AES128_BLOCK_ENCRYPT_CORE_MACROS_SVH
`define AES128_BLOCK_ENCRYPT_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define AES_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define AES_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define AES_ASSERT(label, clk, rst, prop, msg)
`define AES_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

### design/aes_pkg.sv
// Types, constants and helper functions of the AES-128 encryption core.
package aes_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned BlockWidth = 128;

  typedef logic [WordWidth-1:0] word_t;
  typedef logic [BlockWidth-1:0] block_t;

  typedef enum logic [0:0] {
    CFG_KEY_UPPER = 1'b0,
    CFG_KEY_LOWER = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_ROUND,
    ENG_DRAIN
  } eng_state_t;

  // One job handed from the front part to the engine.
  typedef struct packed {
    block_t text;
    block_t key;
  } job_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    unique case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic word_t sub_word(input word_t w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // Next round key from the current one; rcon is the round constant.
  function automatic block_t next_key(input block_t k, input logic [7:0] rcon);
    word_t t;
    word_t w0;
    word_t w1;
    word_t w2;
    word_t w3;
    t  = sub_word({k[23:0], k[31:24]}) ^ {rcon, 24'h0};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  // SubBytes and ShiftRows; state byte (column c, row r) at bits 127-32c-8r.
  function automatic block_t sub_shift(input block_t s);
    block_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 32*c - 8*r -: 8] = sbox(s[127 - 32*((c + r) % 4) - 8*r -: 8]);
      end
    end
    return t;
  endfunction

  function automatic block_t mix(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32*c -: 8];
      a1 = s[119 - 32*c -: 8];
      a2 = s[111 - 32*c -: 8];
      a3 = s[103 - 32*c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32*c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[119 - 32*c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[111 - 32*c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[103 - 32*c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

endpackage

### design/aes128_block_encrypt_core.sv
// Top level of the AES-128 block encryption core.
// The core takes plaintext as four 32-bit column words (first byte in bits 31:24)
// and returns four ciphertext words, with last_word set on the fourth. The key is
// written through the configuration port: index 0 is key bytes 0..7, index 1 is
// key bytes 8..15; the key present when the fourth plaintext word is taken is the
// one used for that block. The front part collects words and queues up to two
// blocks; the round engine computes one round and one key-schedule step per
// cycle, then hands out the four ciphertext words as they are popped; it takes
// the next block only once the fourth word is popped. Input words keep
// arriving while a block is being worked on, until the job queue fills.
module aes128_block_encrypt_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] plain_word,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] cipher_word,
  output logic        last_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import aes_pkg::*;

  logic [63:0] key_upper;
  logic [63:0] key_lower;
  logic        fj_valid;
  logic        fj_ready;
  job_t        fj;
  logic        ej_valid;
  logic        ej_ready;
  job_t        ej;

  assign cfg_ready = 1'b1;

  // Key registers; only the two defined indexes exist.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_upper <= 64'd0;
      key_lower <= 64'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_KEY_UPPER: key_upper <= cfg_data;
        CFG_KEY_LOWER: key_lower <= cfg_data;
        default: ;
      endcase
    end
  end

  aes_front u_front (
    .clk, .rst, .push, .full, .plain_word,
    .key({key_upper, key_lower}),
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  aes_job_queue u_queue (
    .clk, .rst,
    .in_valid(fj_valid), .in_ready(fj_ready), .in_job(fj),
    .out_valid(ej_valid), .out_ready(ej_ready), .out_job(ej)
  );

  aes_engine u_engine (
    .clk, .rst,
    .job_valid(ej_valid), .job_ready(ej_ready), .job(ej),
    .empty, .pop, .cipher_word, .last_word
  );
endmodule

### design/aes_front.sv
// Front part: collects four plaintext words and issues a job into the queue.
module aes_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  aes_pkg::word_t plain_word,
  input  aes_pkg::block_t key,
  output logic           job_valid,
  input  logic           job_ready,
  output aes_pkg::job_t  job
);
  import aes_pkg::*;

  logic [1:0] word_count;
  word_t      buffer [3];
  logic       take;

  assign full      = (word_count == 2'd3) && !job_ready;
  assign take      = push && !full;
  assign job_valid = take && (word_count == 2'd3);
  assign job.text  = {buffer[0], buffer[1], buffer[2], plain_word};
  assign job.key   = key;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count <= 2'd0;
    end else if (take) begin
      word_count <= word_count + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && word_count != 2'd3) begin
      buffer[word_count] <= plain_word;
    end
  end
endmodule

### design/aes_job_queue.sv
// Two-entry queue of jobs between the front part and the round engine.
module aes_job_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  aes_pkg::job_t in_job,
  output logic          out_valid,
  input  logic          out_ready,
  output aes_pkg::job_t out_job
);
  import aes_pkg::*;

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       wr_en;
  logic       rd_en;

  assign in_ready  = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign out_job   = mem[rd_ptr];
  assign wr_en     = in_valid && in_ready;
  assign rd_en     = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= !wr_ptr;
      if (rd_en) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= in_job;
    end
  end
endmodule

### design/aes_engine.sv
// Round engine: one AES round and one key-schedule step per cycle, then word output.
module aes_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_ready,
  input  aes_pkg::job_t  job,
  output logic           empty,
  input  logic           pop,
  output aes_pkg::word_t cipher_word,
  output logic           last_word
);
  import aes_pkg::*;
  `include "aes128_block_encrypt_core_macros.svh"

  eng_state_t state;
  eng_state_t state_next;
  block_t     data;
  block_t     rkey;
  logic [7:0] rcon;
  logic [3:0] round;
  logic [1:0] out_idx;
  block_t     rk_next;
  block_t     ss;
  logic       final_round;
  logic       pop_take;

  assign rk_next     = next_key(rkey, rcon);
  assign ss          = sub_shift(data);
  assign final_round = round == 4'd10;
  assign pop_take    = pop && !empty;

  always_comb begin
    state_next = state;
    unique case (state)
      ENG_IDLE:  if (job_valid) state_next = ENG_ROUND;
      ENG_ROUND: if (final_round) state_next = ENG_DRAIN;
      ENG_DRAIN: if (pop_take && out_idx == 2'd3) state_next = ENG_IDLE;
      default:   state_next = ENG_IDLE;
    endcase
  end

  always_comb begin
    job_ready   = state == ENG_IDLE;
    empty       = state != ENG_DRAIN;
    cipher_word = data[127 - 32*out_idx -: 32];
    last_word   = out_idx == 2'd3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ENG_IDLE;
      round   <= 4'd0;
      out_idx <= 2'd0;
    end else begin
      state <= state_next;
      if (state == ENG_IDLE) begin
        round   <= 4'd1;
        out_idx <= 2'd0;
      end else if (state == ENG_ROUND) begin
        round <= round + 4'd1;
      end else if (pop_take) begin
        out_idx <= out_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ENG_IDLE && job_valid) begin
      data <= job.text ^ job.key;
      rkey <= job.key;
      rcon <= 8'h01;
    end else if (state == ENG_ROUND) begin
      rkey <= rk_next;
      rcon <= xtime(rcon);
      data <= (final_round ? ss : mix(ss)) ^ rk_next;
    end
  end

  `AES_ASSERT(a_round_range, clk, rst, state != ENG_ROUND || (round >= 4'd1 && round <= 4'd10), "round out of range")
  `AES_ASSERT(a_drain_after_final, clk, rst, (state == ENG_ROUND && final_round) |=> state == ENG_DRAIN, "no drain after final round")
  `AES_ASSERT(a_last_ends, clk, rst, (pop_take && last_word) |=> state == ENG_IDLE, "block did not end")
endmodule
